### rtl/pend_pkg.sv
// ----------------------------------------------------------------------------
// pend_pkg: shared constants for the pendulum Euler step unit
// Fixed-point constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package pend_pkg;

    localparam int STATE_W        = 48;
    localparam int STATE_FRAC_DEF = 32;
    localparam int CFG_W          = 31;

    localparam logic [63:0] INT64_MAX_C   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INV_2PI_Q64   = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] GRAVITY_Q32   = 64'd42133629174;
    localparam logic [63:0] DEG_RAD_Q32   = 64'd246083499208;
    localparam logic [63:0] ONE_Q30       = 64'd1073741824;

    // odd Taylor coefficients of sin in Q2.30, innermost first
    localparam logic [63:0] SIN_C11 = -64'sd27;
    localparam logic [63:0] SIN_C9  = 64'sd2959;
    localparam logic [63:0] SIN_C7  = -64'sd213044;
    localparam logic [63:0] SIN_C5  = 64'sd8947849;
    localparam logic [63:0] SIN_C3  = -64'sd178956971;

    localparam logic [CFG_W-1:0] MASS_RST   = 31'd32768;
    localparam logic [CFG_W-1:0] LENGTH_RST = 31'd65536;
    localparam logic [CFG_W-1:0] DAMP_RST   = 31'd32768;
    localparam logic [CFG_W-1:0] TSTEP_RST  = 31'd6554;

    typedef enum logic [1:0] {
        REG_MASS      = 2'd0,
        REG_LENGTH    = 2'd1,
        REG_DAMPING   = 2'd2,
        REG_TIME_STEP = 2'd3
    } reg_idx_t;

endpackage

### rtl/pendulum_euler_step_unit.sv
// ----------------------------------------------------------------------------
// pendulum_euler_step_unit: damped pendulum plant, one Euler step per torque
// Each torque transfer runs 17 products through one shared 32x32 multiplier
// (each in the steps load, four partial products, shift, writeback), with a
// restoring divide, a quotient step and an output step before out_valid.
// Zero mass or length skips the divide. A new torque is taken only once the
// unit is idle again; a held result stalls the next item before output.
// Reset (rst_n, async, active low) zeroes angle and rate and restores config.
// ----------------------------------------------------------------------------
module pendulum_euler_step_unit
    import pend_pkg::*;
#(
    parameter int STATE_FRAC_BITS = STATE_FRAC_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] torque,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] angle_deg,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [6:0] SH_PH   = 7'(STATE_FRAC_BITS + 32);
    localparam logic [6:0] SH_DAMP = 7'(STATE_FRAC_BITS - 16);
    localparam logic [6:0] SH_DV   = 7'(48 - STATE_FRAC_BITS);
    localparam logic [6:0] SH_DEG  = 7'(STATE_FRAC_BITS + 16);
    localparam logic [6:0] DIV_TOP = 7'd111;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_SHIFT, ST_WB, ST_DIV, ST_QUO, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        S_ML, S_PH, S_X, S_X2, S_P1, S_P2, S_P3, S_P4, S_P5, S_SIN,
        S_G1, S_GRAV, S_DAMP, S_DEN, S_DV, S_DA, S_DEG
    } step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [CFG_W-1:0]  mass_reg, len_reg, damp_reg, ts_reg;
    logic [47:0]       angle_reg, angle_next, rate_reg, rate_next;
    logic [31:0]       torque_reg, torque_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_data_reg, out_data_next, deg_reg, deg_next;

    logic [63:0]       a_mag_reg, a_mag_next, b_mag_reg, b_mag_next;
    logic              neg_reg, neg_next;
    logic [6:0]        sh_reg, sh_next;
    logic [1:0]        pcnt_reg, pcnt_next;
    logic [127:0]      pacc_reg, pacc_next, psh_reg, psh_next;

    logic [63:0]       ml_reg, ml_next, tmp_reg, tmp_next, x_reg, x_next;
    logic [63:0]       x2_reg, x2_next, acc_reg, acc_next, sin_reg, sin_next;
    logic [63:0]       num_reg, num_next, accel_reg, accel_next;
    logic [95:0]       den_reg, den_next, rem_reg, rem_next;
    logic [111:0]      dvd_reg, dvd_next;
    logic [62:0]       q_reg, q_next;
    logic              over_reg, over_next;
    logic [6:0]        dcnt_reg, dcnt_next;

    logic [63:0]       op_a, op_b, angle_sx, rate_sx, res, tau_sh, mres, qm;
    logic [6:0]        op_s;
    logic [31:0]       a_part, b_part, ph;
    logic [63:0]       pp;
    logic [127:0]      pp_pos;
    logic signed [33:0] pv, pf;
    logic [95:0]       r2;
    logic              ge, cfg_wr;
    logic [95:0]       den_w;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            add_sat = s[64] ? {1'b1, 63'd0} : INT64_MAX_C;
        else
            add_sat = s[63:0];
    endfunction

    function automatic logic [47:0] clamp_add(input logic [47:0] a, input logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({{17{a[47]}}, a}) + $signed({b[63], b});
        if (s > 65'sh0_0000_7FFF_FFFF_FFFF)
            clamp_add = {1'b0, {47{1'b1}}};
        else if (s < -65'sh0_0000_8000_0000_0000)
            clamp_add = {1'b1, 47'd0};
        else
            clamp_add = s[47:0];
    endfunction

    assign angle_sx = {{16{angle_reg[47]}}, angle_reg};
    assign rate_sx  = {{16{rate_reg[47]}}, rate_reg};
    assign cfg_wr   = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign angle_deg = out_data_reg;

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_MASS:      prdata = {1'b0, mass_reg};
            REG_LENGTH:    prdata = {1'b0, len_reg};
            REG_DAMPING:   prdata = {1'b0, damp_reg};
            REG_TIME_STEP: prdata = {1'b0, ts_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = 64'd0;
        op_b = 64'd0;
        op_s = 7'd30;
        unique case (step_reg)
            S_ML:   begin op_a = {33'd0, mass_reg}; op_b = {33'd0, len_reg}; op_s = 7'd0; end
            S_PH:   begin op_a = angle_sx; op_b = INV_2PI_Q64; op_s = SH_PH; end
            S_X:    begin op_a = tmp_reg; op_b = HALF_PI_Q30; end
            S_X2:   begin op_a = x_reg; op_b = x_reg; end
            S_P1, S_P2, S_P3, S_P4, S_P5:
                    begin op_a = acc_reg; op_b = x2_reg; end
            S_SIN:  begin op_a = acc_reg; op_b = x_reg; end
            S_G1:   begin op_a = ml_reg; op_b = GRAVITY_Q32; op_s = 7'd32; end
            S_GRAV: begin op_a = tmp_reg; op_b = sin_reg; end
            S_DAMP: begin op_a = {33'd0, damp_reg}; op_b = rate_sx; op_s = SH_DAMP; end
            S_DEN:  begin op_a = ml_reg; op_b = {33'd0, len_reg}; op_s = 7'd0; end
            S_DV:   begin op_a = accel_reg; op_b = {33'd0, ts_reg}; op_s = SH_DV; end
            S_DA:   begin op_a = rate_sx; op_b = {33'd0, ts_reg}; op_s = 7'd16; end
            S_DEG:  begin op_a = angle_sx; op_b = DEG_RAD_Q32; op_s = SH_DEG; end
            default: ;
        endcase
    end

    always_comb
    begin
        a_part = pcnt_reg[0] ? a_mag_reg[63:32] : a_mag_reg[31:0];
        b_part = pcnt_reg[1] ? b_mag_reg[63:32] : b_mag_reg[31:0];
        pp     = a_part * b_part;
        unique case (pcnt_reg)
            2'd0:    pp_pos = {64'd0, pp};
            2'd1,
            2'd2:    pp_pos = {32'd0, pp, 32'd0};
            default: pp_pos = {pp, 64'd0};
        endcase
        mres   = (psh_reg[127:63] == 65'd0) ? psh_reg[63:0] : INT64_MAX_C;
        res    = neg_reg ? (64'd0 - mres) : mres;
        ph     = neg_reg ? (32'd0 - psh_reg[31:0]) : psh_reg[31:0];
        pv     = {{2{ph[31]}}, ph};
        if (pv > 34'sd1073741824)
            pf = 34'sd2147483648 - pv;
        else if (pv < -34'sd1073741824)
            pf = -34'sd2147483648 - pv;
        else
            pf = pv;
        tau_sh = {{16{torque_reg[31]}}, torque_reg, 16'd0};
        den_w  = psh_reg[95:0];
        r2     = {rem_reg[94:0], dvd_reg[111]};
        ge     = (r2 >= den_reg);
        qm     = over_reg ? INT64_MAX_C : {1'b0, q_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        angle_next     = angle_reg;
        rate_next      = rate_reg;
        torque_next    = torque_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        deg_next       = deg_reg;
        a_mag_next     = a_mag_reg;
        b_mag_next     = b_mag_reg;
        neg_next       = neg_reg;
        sh_next        = sh_reg;
        pcnt_next      = pcnt_reg;
        pacc_next      = pacc_reg;
        psh_next       = psh_reg;
        ml_next        = ml_reg;
        tmp_next       = tmp_reg;
        x_next         = x_reg;
        x2_next        = x2_reg;
        acc_next       = acc_reg;
        sin_next       = sin_reg;
        num_next       = num_reg;
        accel_next     = accel_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        q_next         = q_reg;
        over_next      = over_reg;
        dcnt_next      = dcnt_reg;

        // drop the result once the consumer takes it
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    torque_next = torque;
                    step_next   = S_ML;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                a_mag_next = mag64(op_a);
                b_mag_next = mag64(op_b);
                neg_next   = op_a[63] ^ op_b[63];
                sh_next    = op_s;
                pacc_next  = 128'd0;
                pcnt_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                pacc_next = pacc_reg + pp_pos;
                pcnt_next = pcnt_reg + 2'd1;
                if (pcnt_reg == 2'd3)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                psh_next   = pacc_reg >> sh_reg;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = ST_LOAD;
                step_next  = step_t'(step_reg + 5'd1);
                unique case (step_reg)
                    S_ML:   ml_next  = res;
                    S_PH:   tmp_next = {{30{pf[33]}}, pf};
                    S_X:    x_next   = res;
                    S_X2:
                    begin
                        x2_next  = res;
                        acc_next = SIN_C11;
                    end
                    S_P1:   acc_next = SIN_C9 + res;
                    S_P2:   acc_next = SIN_C7 + res;
                    S_P3:   acc_next = SIN_C5 + res;
                    S_P4:   acc_next = SIN_C3 + res;
                    S_P5:   acc_next = ONE_Q30 + res;
                    S_SIN:  sin_next = res;
                    S_G1:   tmp_next = res;
                    S_GRAV: num_next = add_sat(tau_sh, 64'd0 - res);
                    S_DAMP: num_next = add_sat(num_reg, 64'd0 - res);
                    S_DEN:
                    begin
                        den_next = den_w;
                        if (den_w != 96'd0)
                        begin
                            rem_next   = 96'd0;
                            dvd_next   = {mag64(num_reg), 48'd0};
                            q_next     = 63'd0;
                            over_next  = 1'b0;
                            dcnt_next  = DIV_TOP;
                            step_next  = S_DEN;
                            state_next = ST_DIV;
                        end
                        else
                            accel_next = 64'd0;
                    end
                    S_DV:   rate_next  = clamp_add(rate_reg, res);
                    S_DA:   angle_next = clamp_add(angle_reg, res);
                    S_DEG:
                    begin
                        if (!res[63] && (res[62:31] != 32'd0))
                            deg_next = 32'h7FFF_FFFF;
                        else if (res[63] && (res[62:31] != 32'hFFFF_FFFF))
                            deg_next = 32'h8000_0000;
                        else
                            deg_next = res[31:0];
                        step_next  = S_DEG;
                        state_next = ST_OUT;
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                rem_next  = ge ? (r2 - den_reg) : r2;
                dvd_next  = {dvd_reg[110:0], 1'b0};
                q_next    = {q_reg[61:0], ge};
                over_next = over_reg | (ge && (dcnt_reg >= 7'd63));
                dcnt_next = dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd0)
                    state_next = ST_QUO;
            end
            ST_QUO:
            begin
                accel_next = num_reg[63] ? (64'd0 - qm) : qm;
                step_next  = S_DV;
                state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = deg_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= S_ML;
            out_valid_reg <= 1'b0;
            angle_reg     <= 48'd0;
            rate_reg      <= 48'd0;
            mass_reg      <= MASS_RST;
            len_reg       <= LENGTH_RST;
            damp_reg      <= DAMP_RST;
            ts_reg        <= TSTEP_RST;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            angle_reg     <= angle_next;
            rate_reg      <= rate_next;
            if (cfg_wr)
            begin
                unique case (reg_idx_t'(paddr[3:2]))
                    REG_MASS:      mass_reg <= pwdata[CFG_W-1:0];
                    REG_LENGTH:    len_reg  <= pwdata[CFG_W-1:0];
                    REG_DAMPING:   damp_reg <= pwdata[CFG_W-1:0];
                    REG_TIME_STEP: ts_reg   <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        torque_reg   <= torque_next;
        out_data_reg <= out_data_next;
        deg_reg      <= deg_next;
        a_mag_reg    <= a_mag_next;
        b_mag_reg    <= b_mag_next;
        neg_reg      <= neg_next;
        sh_reg       <= sh_next;
        pcnt_reg     <= pcnt_next;
        pacc_reg     <= pacc_next;
        psh_reg      <= psh_next;
        ml_reg       <= ml_next;
        tmp_reg      <= tmp_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        acc_reg      <= acc_next;
        sin_reg      <= sin_next;
        num_reg      <= num_next;
        accel_reg    <= accel_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        q_reg        <= q_next;
        over_reg     <= over_next;
        dcnt_reg     <= dcnt_next;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_LOAD && step_reg == S_ML))
        else $error("unit not busy after input transfer");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (den_reg != 96'd0))
        else $error("divider running on zero divisor");

    a_phase_folded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && step_reg == S_X) |->
        (($signed(tmp_reg) <= 64'sd1073741824) && ($signed(tmp_reg) >= -64'sd1073741824)))
        else $error("sine argument not folded into half turn");
`endif

endmodule
